// ===== sv/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
package tcw_pkg;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam logic [3:0] GRAY       = 4'd7;
  localparam logic [15:0] BLANK_CELL = {4'd0, GRAY, CH_SPACE};

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] char_code;
    logic [3:0] fg_color;
    logic [3:0] bg_color;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } req_word_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
  } rsp_word_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_BLANK,
    ST_CLEAR,
    ST_DONE
  } state_t;

endpackage

// ===== sv/text_console_writer.sv =====
// Text console writer: screen memory, cursor and control FSM.
//
// Requests arrive on req (req_valid/req_stall); one response per request
// leaves on rsp (rsp_valid/rsp_stall). A word moves at a clock edge where
// valid is high and stall is low.
// Each response carries the cursor after the operation and, for a read,
// the cell (char in the low byte, bg<<4|fg in the high byte), else zero.
// A scroll (line wrap or newline on the last row) copies the rows below
// up one row and then blanks the bottom row, one cell copied or blanked
// a cycle, through the single screen RAM write port.
// After reset the block sweeps every cell to blank gray-on-black, with
// req_stall high while it does so.
// A response held by rsp_stall does not block the next request: it is
// taken and worked on, and its response waits until the output register
// frees up. req_stall is high whenever an operation is in progress.
module text_console_writer #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  tcw_pkg::req_word_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output tcw_pkg::rsp_word_t rsp
);

  localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
  localparam int KEEP  = (SCREEN_ROWS - 1) * SCREEN_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(SCREEN_COLS);
  localparam int RW    = $clog2(SCREEN_ROWS);

  tcw_pkg::state_t state, state_next;

  logic [AW-1:0] cnt, cnt_next;
  logic [RW-1:0] cur_row, cur_row_next;
  logic [CW-1:0] cur_col, cur_col_next;
  logic          wr_pend, wr_pend_next;
  logic [AW-1:0] wr_addr_d, wr_addr_d_next;
  logic [15:0]   cell_hold, cell_hold_next;
  logic          rd_ok, rd_ok_next;
  tcw_pkg::rsp_word_t rsp_next;
  logic          rsp_valid_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  logic          accept;
  logic          is_put, put_nl, put_cr, put_bs, put_ord;
  logic          col_last, row_last, need_scroll, rsp_free;
  logic [CW-1:0] col_sel;
  logic [31:0]   put_lin, rd_lin;
  logic          rd_in_range;

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req_stall = (state != tcw_pkg::ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  assign is_put  = (req.op == tcw_pkg::OP_PUT);
  assign put_nl  = is_put && (req.char_code == tcw_pkg::CH_NEWLINE);
  assign put_cr  = is_put && (req.char_code == tcw_pkg::CH_RETURN);
  assign put_bs  = is_put && (req.char_code == tcw_pkg::CH_BACKSPACE);
  assign put_ord = is_put && !put_nl && !put_cr && !put_bs;

  assign col_last = (cur_col == CW'(SCREEN_COLS - 1));
  assign row_last = (cur_row == RW'(SCREEN_ROWS - 1));
  assign need_scroll = row_last && (put_nl || (put_ord && col_last));

  // Backspace targets the cell left of the cursor
  assign col_sel = put_bs ? (cur_col - CW'(1)) : cur_col;
  assign put_lin = 32'(cur_row) * 32'(SCREEN_COLS) + 32'(col_sel);
  assign rd_lin  = 32'(req.read_row) * 32'(SCREEN_COLS) + 32'(req.read_col);
  assign rd_in_range = (32'(req.read_row) < 32'(SCREEN_ROWS)) &&
                       (32'(req.read_col) < 32'(SCREEN_COLS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcw_pkg::ST_INIT;
      cnt       <= '0;
      cur_row   <= '0;
      cur_col   <= '0;
      wr_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      cur_row   <= cur_row_next;
      cur_col   <= cur_col_next;
      wr_pend   <= wr_pend_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_d <= wr_addr_d_next;
    cell_hold <= cell_hold_next;
    rd_ok     <= rd_ok_next;
    rsp       <= rsp_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tcw_pkg::ST_INIT: begin
        if (cnt == AW'(CELLS - 1)) state_next = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          if (req.op == tcw_pkg::OP_CLEAR)     state_next = tcw_pkg::ST_CLEAR;
          else if (req.op == tcw_pkg::OP_READ) state_next = tcw_pkg::ST_READ;
          else if (need_scroll)                state_next = tcw_pkg::ST_COPY;
          else                                 state_next = tcw_pkg::ST_DONE;
        end
      end
      tcw_pkg::ST_READ: state_next = tcw_pkg::ST_DONE;
      tcw_pkg::ST_COPY: begin
        if (cnt == AW'(KEEP - 1)) state_next = tcw_pkg::ST_BLANK;
      end
      tcw_pkg::ST_BLANK: begin
        if (!wr_pend && cnt == AW'(CELLS - 1)) state_next = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_CLEAR: begin
        if (cnt == AW'(CELLS - 1)) state_next = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_DONE: begin
        if (rsp_free) state_next = tcw_pkg::ST_IDLE;
      end
      default: state_next = tcw_pkg::ST_INIT;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cnt_next       = cnt;
    cur_row_next   = cur_row;
    cur_col_next   = cur_col;
    wr_pend_next   = 1'b0;
    wr_addr_d_next = wr_addr_d;
    cell_hold_next = cell_hold;
    rd_ok_next     = rd_ok;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;
    ram_we         = 1'b0;
    ram_waddr      = put_lin[AW-1:0];
    ram_wdata      = {req.bg_color, req.fg_color, req.char_code};
    ram_raddr      = rd_lin[AW-1:0];

    // Finish a copy whose source was read last cycle
    if (wr_pend) begin
      ram_we    = 1'b1;
      ram_waddr = wr_addr_d;
      ram_wdata = ram_rdata;
    end

    case (state)
      tcw_pkg::ST_INIT, tcw_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = tcw_pkg::BLANK_CELL;
        cnt_next  = cnt + AW'(1);
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          cnt_next       = '0;
          cell_hold_next = '0;
          rd_ok_next     = rd_in_range;
          case (req.op)
            tcw_pkg::OP_PUT: begin
              if (put_nl || put_cr) begin
                cur_col_next = '0;
                if (put_nl && !row_last) cur_row_next = cur_row + RW'(1);
              end else if (put_bs) begin
                if (cur_col != '0) begin
                  cur_col_next = col_sel;
                  ram_we       = 1'b1;
                  ram_wdata    = {req.bg_color, req.fg_color, tcw_pkg::CH_SPACE};
                end
              end else begin
                ram_we = 1'b1;
                if (col_last) begin
                  cur_col_next = '0;
                  if (!row_last) cur_row_next = cur_row + RW'(1);
                end else begin
                  cur_col_next = cur_col + CW'(1);
                end
              end
            end
            tcw_pkg::OP_CLEAR: begin
              cur_row_next = '0;
              cur_col_next = '0;
            end
            default: ;
          endcase
        end
      end
      tcw_pkg::ST_READ: begin
        cell_hold_next = rd_ok ? ram_rdata : 16'd0;
      end
      tcw_pkg::ST_COPY: begin
        ram_raddr      = cnt + AW'(SCREEN_COLS);
        wr_pend_next   = 1'b1;
        wr_addr_d_next = cnt;
        cnt_next       = cnt + AW'(1);
      end
      tcw_pkg::ST_BLANK: begin
        if (!wr_pend) begin
          ram_we    = 1'b1;
          ram_waddr = cnt;
          ram_wdata = tcw_pkg::BLANK_CELL;
          cnt_next  = cnt + AW'(1);
        end
      end
      tcw_pkg::ST_DONE: begin
        if (rsp_free) begin
          rsp_valid_next      = 1'b1;
          rsp_next.cell_value = cell_hold;
          rsp_next.cursor_row = 5'(cur_row);
          rsp_next.cursor_col = 7'(cur_col);
        end
      end
      default: ;
    endcase
  end

  a_no_write_when_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == tcw_pkg::ST_READ || state == tcw_pkg::ST_DONE) |-> !ram_we)
    else $error("screen memory written outside an update");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (32'(cur_row) < 32'(SCREEN_ROWS)) && (32'(cur_col) < 32'(SCREEN_COLS)))
    else $error("cursor outside the screen");

  a_copy_pending: assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> (state == tcw_pkg::ST_COPY || state == tcw_pkg::ST_BLANK))
    else $error("scroll copy pending outside a scroll");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    (rsp_free && state != tcw_pkg::ST_DONE) |=> !rsp_valid)
    else $error("response produced without a finished operation");

endmodule

// ===== sv/tcw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/tb_text_console_writer.sv =====
// Testbench for the text console writer: puts, control bytes, scroll, clear and reads.
module tb_text_console_writer;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLS * ROWS;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int TARGET_WORDS = 700;
  // Scrolls and clears are the slowest operations, so this leaves several times
  // the slowest run that this stimulus could produce.
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int DRAIN_CYCLES = 2100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  tcw_pkg::req_word_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  tcw_pkg::rsp_word_t rsp;

  logic [15:0] shadow_cells [CELLS];
  int cur_row;
  int cur_col;
  int scrolls = 0;
  int clears = 0;
  tcw_pkg::rsp_word_t awaited_views [$];
  int words_sent = 0;
  int views_checked = 0;
  int mismatches = 0;
  int cycles = 0;
  int long_hold = 0;
  bit gaps_off = 1'b0;

  text_console_writer #(
    .SCREEN_COLS(COLS),
    .SCREEN_ROWS(ROWS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles,
               awaited_views.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void blank_screen();
    int i;
    for (i = 0; i < CELLS; i++) shadow_cells[i] = tcw_pkg::BLANK_CELL;
    cur_row = 0;
    cur_col = 0;
  endfunction

  function automatic void next_line();
    int i;
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      // shift every row up one, blank the bottom row, park the cursor there
      for (i = 0; i < CELLS - COLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
      for (i = CELLS - COLS; i < CELLS; i++) shadow_cells[i] = tcw_pkg::BLANK_CELL;
      cur_row = ROWS - 1;
      scrolls++;
    end
  endfunction

  function automatic tcw_pkg::rsp_word_t console_step(input tcw_pkg::req_word_t w);
    tcw_pkg::rsp_word_t view;
    view = '0;
    case (w.op)
      tcw_pkg::OP_PUT: begin
        if (w.char_code == tcw_pkg::CH_NEWLINE) begin
          next_line();
        end else if (w.char_code == tcw_pkg::CH_RETURN) begin
          cur_col = 0;
        end else if (w.char_code == tcw_pkg::CH_BACKSPACE) begin
          if (cur_col > 0) begin
            cur_col--;
            shadow_cells[cur_row * COLS + cur_col] =
              {w.bg_color, w.fg_color, tcw_pkg::CH_SPACE};
          end
        end else begin
          shadow_cells[cur_row * COLS + cur_col] = {w.bg_color, w.fg_color, w.char_code};
          cur_col++;
          if (cur_col >= COLS) next_line();
        end
      end
      tcw_pkg::OP_CLEAR: begin
        blank_screen();
        clears++;
      end
      tcw_pkg::OP_READ: begin
        if (w.read_row < ROWS && w.read_col < COLS)
          view.cell_value = shadow_cells[w.read_row * COLS + w.read_col];
      end
      default: ;
    endcase
    view.cursor_row = cur_row[4:0];
    view.cursor_col = cur_col[6:0];
    return view;
  endfunction

  function automatic void flag_error(input string what, input tcw_pkg::rsp_word_t want,
                                     input tcw_pkg::rsp_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s at cycle %0d: expected cell %h row %0d col %0d, got cell %h row %0d col %0d",
               what, cycles, want.cell_value, want.cursor_row, want.cursor_col,
               got.cell_value, got.cursor_row, got.cursor_col);
  endfunction

  always @(posedge clk) begin
    tcw_pkg::rsp_word_t want;
    if (!rst && rsp_valid === 1'b1 && !rsp_stall) begin
      views_checked++;
      if (awaited_views.size() == 0) begin
        flag_error("unexpected word", '0, rsp);
      end else begin
        want = awaited_views.pop_front();
        if (rsp.cell_value !== want.cell_value || rsp.cursor_row !== want.cursor_row ||
            rsp.cursor_col !== want.cursor_col)
          flag_error("mismatch", want, rsp);
      end
    end
  end

  function automatic int pick_gap();
    return gaps_off ? 0 : int'($urandom_range(0, 6));
  endfunction

  // Receiver: stall a random number of cycles per word, or a long stretch on request.
  initial begin
    int n;
    forever begin
      if (long_hold > 0) begin
        n = long_hold;
        long_hold = 0;
      end else begin
        n = pick_gap();
      end
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (rsp_valid !== 1'b1 || rst);
    end
  end

  // Hold valid across back-to-back words; only drop it when a gap is drawn.
  task automatic offer_word(input tcw_pkg::req_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    awaited_views.push_back(console_step(w));
    if (w.op != OP_SPARE) words_sent++;
  endtask

  task automatic put_byte(input logic [7:0] ch, input logic [3:0] fg, input logic [3:0] bg);
    tcw_pkg::req_word_t w;
    w = tcw_pkg::req_word_t'($urandom);
    w.op = tcw_pkg::OP_PUT;
    w.char_code = ch;
    w.fg_color = fg;
    w.bg_color = bg;
    offer_word(w);
  endtask

  task automatic read_cell(input logic [4:0] row, input logic [6:0] col);
    tcw_pkg::req_word_t w;
    w = tcw_pkg::req_word_t'($urandom);
    w.op = tcw_pkg::OP_READ;
    w.read_row = row;
    w.read_col = col;
    offer_word(w);
  endtask

  task automatic test_directed();
    tcw_pkg::req_word_t w;
    read_cell(0, 0);
    read_cell(5'(ROWS - 1), 7'(COLS - 1));
    read_cell(5'(ROWS), 0);
    read_cell(0, 7'(COLS));
    read_cell(5'h1f, 7'h7f);
    put_byte(8'h00, 4'h0, 4'h0);
    put_byte(8'hff, 4'hf, 4'hf);
    put_byte(8'h41, 4'ha, 4'h5);
    read_cell(0, 1);
    put_byte(tcw_pkg::CH_BACKSPACE, 4'h3, 4'h4);
    read_cell(0, 2);
    put_byte(tcw_pkg::CH_RETURN, 4'h1, 4'h2);
    // backspace at column 0 must leave cell and cursor alone
    put_byte(tcw_pkg::CH_BACKSPACE, 4'h3, 4'h4);
    read_cell(0, 0);
    put_byte(tcw_pkg::CH_NEWLINE, 4'h0, 4'h0);
    w = '1;
    w.op = OP_SPARE;
    offer_word(w);
    put_byte(8'h7f, 4'h9, 4'h6);
    read_cell(1, 0);
    w = tcw_pkg::req_word_t'($urandom);
    w.op = tcw_pkg::OP_CLEAR;
    offer_word(w);
    read_cell(0, 0);
    read_cell(1, 0);
  endtask

  task automatic test_line_wrap();
    int i;
    for (i = 0; i < COLS; i++)
      put_byte(8'($urandom_range(33, 126)), 4'($urandom), 4'($urandom));
    read_cell(5'(cur_row - 1), 7'(COLS - 1));
    read_cell(5'(cur_row - 1), 0);
    put_byte(tcw_pkg::CH_BACKSPACE, 4'($urandom), 4'($urandom));
    read_cell(5'(cur_row - 1), 7'(COLS - 1));
  endtask

  task automatic test_scroll();
    int i;
    while (cur_row < ROWS - 1) begin
      repeat ($urandom_range(0, 4))
        put_byte(8'($urandom_range(33, 126)), 4'($urandom), 4'($urandom));
      put_byte(tcw_pkg::CH_NEWLINE, 4'($urandom), 4'($urandom));
    end
    put_byte(8'h42, 4'hc, 4'h1);
    put_byte(tcw_pkg::CH_NEWLINE, 4'h0, 4'h0);
    read_cell(5'(ROWS - 2), 0);
    read_cell(5'(ROWS - 1), 0);
    put_byte(tcw_pkg::CH_NEWLINE, 4'h0, 4'h0);
    // a full bottom line wraps and scrolls again
    for (i = 0; i < COLS; i++)
      put_byte(8'($urandom_range(33, 126)), 4'($urandom), 4'($urandom));
    read_cell(5'(ROWS - 2), 7'(COLS - 1));
    read_cell(5'(ROWS - 1), 0);
  endtask

  task automatic test_output_backpressure();
    int i;
    long_hold = 400;
    for (i = 0; i < 30; i++) begin
      if (i % 2 == 1) read_cell(5'(cur_row), 7'($urandom_range(0, COLS - 1)));
      else put_byte(8'($urandom_range(33, 126)), 4'($urandom), 4'($urandom));
    end
  endtask

  task automatic test_back_to_back();
    int i;
    gaps_off = 1'b1;
    for (i = 0; i < 40; i++) begin
      if (i % 3 == 0)
        read_cell(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLS - 1)));
      else put_byte(8'($urandom_range(33, 126)), 4'($urandom), 4'($urandom));
    end
    gaps_off = 1'b0;
  endtask

  task automatic test_random_text();
    int kind;
    int len;
    int i;
    logic [3:0] fg;
    logic [3:0] bg;
    tcw_pkg::req_word_t w;
    while (words_sent < TARGET_WORDS) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        // one run of text in one color pair, now and then a backspace
        len = ($urandom_range(0, 6) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 24);
        fg = 4'($urandom);
        bg = 4'($urandom);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(0, 11) == 0)
            put_byte(tcw_pkg::CH_BACKSPACE, 4'($urandom), 4'($urandom));
          else put_byte(8'($urandom), fg, bg);
        end
        case ($urandom_range(0, 3))
          0, 1: put_byte(tcw_pkg::CH_NEWLINE, fg, bg);
          2: put_byte(tcw_pkg::CH_RETURN, fg, bg);
          default: ;
        endcase
      end else if (kind < 88) begin
        // read back mostly on the cursor row, where recent text landed
        repeat ($urandom_range(1, 4))
          read_cell($urandom_range(0, 1) ? 5'(cur_row) : 5'($urandom_range(0, ROWS - 1)),
                    7'($urandom_range(0, COLS - 1)));
      end else if (kind < 90) begin
        w = tcw_pkg::req_word_t'($urandom);
        w.op = tcw_pkg::OP_CLEAR;
        offer_word(w);
      end else begin
        w = tcw_pkg::req_word_t'($urandom);
        offer_word(w);
      end
    end
  endtask

  initial begin
    blank_screen();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_line_wrap();
    test_scroll();
    test_output_backpressure();
    test_back_to_back();
    test_random_text();
    req_valid <= 1'b0;
    while (awaited_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d request words, checked %0d responses in %0d cycles",
             words_sent, views_checked, cycles);
    $display("Run went through %0d scrolls and %0d screen clears", scrolls, clears);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
